/* design/ses_pkg.sv */
// types, constants and handshake structs shared by the summary statistics engine
// no dependencies
`default_nettype none

package ses_pkg;

  localparam int unsigned MaxSamplesDef = 1024;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned SampleW       = 32;
  localparam int unsigned ValueW        = 64;
  localparam int unsigned IdxW          = 4;

  localparam logic [ValueW-1:0] Int64Max = 64'h7FFF_FFFF_FFFF_FFFF;

  // result order of one burst
  localparam logic [IdxW-1:0] StatCount  = 4'd0;
  localparam logic [IdxW-1:0] StatSum    = 4'd1;
  localparam logic [IdxW-1:0] StatMean   = 4'd2;
  localparam logic [IdxW-1:0] StatMode   = 4'd3;
  localparam logic [IdxW-1:0] StatQ1     = 4'd4;
  localparam logic [IdxW-1:0] StatQ2     = 4'd5;
  localparam logic [IdxW-1:0] StatQ3     = 4'd6;
  localparam logic [IdxW-1:0] StatRange  = 4'd7;
  localparam logic [IdxW-1:0] StatMedian = 4'd8;
  localparam logic [IdxW-1:0] StatVar    = 4'd9;
  localparam logic [IdxW-1:0] StatStddev = 4'd10;
  localparam logic [IdxW-1:0] StatIqr    = 4'd11;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_sample;
  } ses_in_t;

  typedef struct packed {
    logic [IdxW-1:0]          stat_index;
    logic signed [ValueW-1:0] stat_value;
    logic                     stat_invalid;
    logic                     last_result;
  } ses_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_MEAN,
    ST_SWEEP,
    ST_MUL,
    ST_VAR,
    ST_SQRT,
    ST_EMIT
  } ses_state_e;

  typedef struct packed {
    logic take;
    logic shift;
    logic place;
    logic mean_go;
    logic sweep_go;
    logic sweep;
    logic mul_go;
    logic var_go;
    logic sqrt_go;
    logic emit_go;
    logic emit_step;
    logic clear;
  } ses_cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic p_one;
    logic larger;
    logic last;
    logic div_done;
    logic sweep_done;
    logic mul_done;
    logic sqrt_done;
    logic few;
    logic emit_last;
  } ses_sts_t;

endpackage

`default_nettype wire

/* design/summary_statistics_engine.sv */
// Samples are taken one request at a time and inserted into an ascending memory, each
// stored sample greater than the new one moved up one entry per cycle. After the flagged
// last sample the engine computes the statistics, then gives the twelve results, one per
// accepted request; the bit-serial divider runs for the mean, then for the variance when at
// least two samples are stored. Input stays stalled until the last result is taken. Samples
// beyond MAX_SAMPLES are dropped and mark every result invalid.
// top level; depends on ses_pkg, ses_ctrl and ses_dpath
`default_nettype none

module summary_statistics_engine import ses_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ses_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ses_out_t out_data_o
);

  ses_cmd_t cmd;
  ses_sts_t sts;

  ses_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_sample),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  ses_dpath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

/* design/ses_div.sv */
// restoring unsigned divider, one quotient bit per cycle
// uses nothing from the package
`default_nettype none

module ses_div #(
  parameter int unsigned NW = 86,
  parameter int unsigned DW = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NW + 1);

  logic [CntW-1:0] cnt_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   div_q;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_nx;
  logic            ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[NW-1]};
    ge     = rem_sh >= {1'b0, div_q};
    rem_nx = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= rem_nx[DW-1:0];
    end
  end

  assign done_o = (cnt_q == '0);
  assign quot_o = quo_q;

endmodule

`default_nettype wire

/* design/ses_dpath.sv */
// datapath: sorted sample memory, sweep pipeline, multiplier, divider, square root
// depends on ses_pkg and ses_div
`default_nettype none

module ses_dpath import ses_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ses_cmd_t cmd_i,
  input  ses_in_t  in_data_i,
  output ses_sts_t sts_o,
  output ses_out_t out_data_o
);

  localparam int unsigned AW   = $clog2(MAX_SAMPLES);
  localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW   = SampleW + CW;
  localparam int unsigned AccW = 64 + CW;
  localparam int unsigned NW   = 64 + 2 * CW;
  localparam int unsigned DW   = 2 * CW;
  localparam int unsigned MulCntW = $clog2(CW + 1);
  localparam logic [31:0] FracMask = 32'((64'd1 << FRAC_BITS) - 64'd1);

  // ingest
  logic signed [31:0] store_q [MAX_SAMPLES];
  logic signed [31:0] rd_q;
  logic signed [31:0] v_q;
  logic [AW-1:0]      p_q;
  logic [CW-1:0]      count_q;
  logic signed [SW-1:0] sum_q;
  logic               dropped_q;
  logic               last_q;

  logic [AW-1:0]      ra;
  logic [CW-1:0]      cm1;
  logic               we;
  logic signed [31:0] wd;
  logic               full;

  assign full = (count_q == CW'(MAX_SAMPLES));
  assign cm1  = count_q - CW'(1);
  assign we   = cmd_i.shift | cmd_i.place;
  assign wd   = cmd_i.shift ? rd_q : v_q;

  // sweep counter and pipeline
  logic [CW-1:0] sa_q;
  logic          issue;
  logic          v1_q, v2_q, v3_q;

  always_comb begin
    priority if (cmd_i.take) ra = cm1[AW-1:0];
    else if (cmd_i.shift)    ra = p_q - AW'(2);
    else                     ra = sa_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) store_q[p_q] <= wd;
    rd_q <= store_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sum_q     <= '0;
      dropped_q <= 1'b0;
      last_q    <= 1'b0;
    end else if (cmd_i.clear) begin
      count_q   <= '0;
      sum_q     <= '0;
      dropped_q <= 1'b0;
    end else if (cmd_i.take) begin
      last_q <= in_data_i.last_sample;
      if (full) begin
        dropped_q <= 1'b1;
      end else begin
        count_q <= count_q + CW'(1);
        sum_q   <= sum_q + SW'(in_data_i.sample);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      v_q <= in_data_i.sample;
      p_q <= count_q[AW-1:0];
    end else if (cmd_i.shift) begin
      p_q <= p_q - AW'(1);
    end
  end

  // shared divider: mean first, then the variance numerator
  logic [SW-1:0] sum_abs;
  logic [NW-1:0] prod_q;
  logic [DW-1:0] rsq_q;
  logic [DW-1:0] dv_q;
  logic [NW-1:0] num;
  logic [NW-1:0] div_a;
  logic [DW-1:0] div_b;
  logic          div_done;
  logic [NW-1:0] quot;

  assign sum_abs = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign num     = prod_q - NW'(rsq_q);
  assign div_a   = cmd_i.mean_go ? NW'(sum_abs) : num;
  assign div_b   = cmd_i.mean_go ? DW'(count_q) : dv_q;

  ses_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mean_go | cmd_i.var_go),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  logic signed [31:0] mean_q;
  logic [31:0]        qlow;
  assign qlow = quot[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_go) mean_q <= sum_q[SW-1] ? -qlow : qlow;
  end

  // sweep: read every stored sample once
  logic [CW-1:0]      i1_q;
  logic [31:0]        da_q;
  logic [63:0]        sq_q;
  logic [AccW-1:0]    acc_q;
  logic signed [31:0] prev_q;
  logic [CW-1:0]      run_q;
  logic [CW-1:0]      best_len_q;
  logic signed [31:0] best_val_q;
  logic signed [31:0] s_lo_q, s_hi_q, s_q1_q, s_q2_q, s_q3_q, s_m1_q;

  logic signed [32:0] dsub;
  logic [32:0]        dabs;
  logic [CW-1:0]      run_n;
  logic [CW+1:0]      n3;
  logic [CW-1:0]      idx_q1, idx_q2, idx_q3, idx_m1;

  assign issue  = cmd_i.sweep && (sa_q != count_q);
  assign n3     = {count_q, 1'b0} + {2'b00, count_q};
  assign idx_q1 = count_q >> 2;
  assign idx_q2 = count_q >> 1;
  assign idx_q3 = n3[CW+1:2];
  assign idx_m1 = idx_q2 - CW'(1);

  always_comb begin
    dsub  = {rd_q[31], rd_q} - {mean_q[31], mean_q};
    dabs  = dsub[32] ? 33'(-dsub) : 33'(dsub);
    run_n = (rd_q == prev_q) ? (run_q + CW'(1)) : CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (cmd_i.sweep_go) sa_q <= '0;
      else if (issue)     sa_q <= sa_q + CW'(1);
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) i1_q <= sa_q;
    if (v1_q) begin
      da_q <= dabs[31:0];
      prev_q <= rd_q;
      if (i1_q == '0) begin
        run_q      <= CW'(1);
        best_len_q <= CW'(1);
        best_val_q <= '0;
        s_lo_q     <= rd_q;
      end else begin
        run_q <= run_n;
        if (run_n > best_len_q) begin
          best_len_q <= run_n;
          best_val_q <= rd_q;
        end
      end
      if (i1_q == cm1)    s_hi_q <= rd_q;
      if (i1_q == idx_q1) s_q1_q <= rd_q;
      if (i1_q == idx_q2) s_q2_q <= rd_q;
      if (i1_q == idx_q3) s_q3_q <= rd_q;
      if (i1_q == idx_m1) s_m1_q <= rd_q;
    end
    if (v2_q) sq_q <= 64'(da_q) * 64'(da_q);
    if (cmd_i.sweep_go) acc_q <= '0;
    else if (v3_q)      acc_q <= acc_q + AccW'(sq_q);
  end

  // n * sum of squares by shift and add, and the squared mean residue
  logic [NW-1:0]       mcand_q;
  logic [CW-1:0]       mplier_q;
  logic [MulCntW-1:0]  mcnt_q;
  logic [CW-1:0]       r_abs_q;
  logic signed [CW+32:0] nm;
  logic signed [CW+32:0] r_full;
  logic [CW+32:0]        r_mag;

  always_comb begin
    nm     = $signed({1'b0, count_q}) * $signed(mean_q);
    r_full = $signed({sum_q[SW-1], sum_q}) - nm;
    r_mag  = r_full[CW+32] ? (CW+33)'(-r_full) : (CW+33)'(r_full);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= MulCntW'(CW);
    end else if (cmd_i.mul_go) begin
      mcnt_q <= '0;
    end else if (mcnt_q != MulCntW'(CW)) begin
      mcnt_q <= mcnt_q + MulCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      mcand_q  <= NW'(acc_q);
      mplier_q <= count_q;
      prod_q   <= '0;
      r_abs_q  <= r_mag[CW-1:0];
      dv_q     <= DW'(count_q) * DW'(cm1);
    end else if (mcnt_q != MulCntW'(CW)) begin
      if (mplier_q[0]) prod_q <= prod_q + mcand_q;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
    rsq_q <= DW'(r_abs_q) * DW'(r_abs_q);
  end

  // variance and integer square root
  logic [NW-1:0] vq;
  logic          vsat;
  logic [63:0]   var_q;
  logic          var_sat_q;
  logic [63:0]   sv_q, sres_q, sbit_q;
  logic [63:0]   strial;

  assign vq     = quot >> FRAC_BITS;
  assign vsat   = vq > NW'(Int64Max);
  assign strial = sres_q + sbit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbit_q <= '0;
    end else if (cmd_i.sqrt_go) begin
      sbit_q <= 64'd1 << 62;
    end else if (sbit_q != '0) begin
      sbit_q <= sbit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_go) begin
      var_q     <= vsat ? Int64Max : vq[63:0];
      var_sat_q <= vsat;
      sv_q      <= ((quot >> 64) != '0) ? '1 : quot[63:0];
      sres_q    <= '0;
    end else if (sbit_q != '0) begin
      if (sv_q >= strial) begin
        sv_q   <= sv_q - strial;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
    end
  end

  // result sequencing
  logic [IdxW-1:0] k_q;
  logic            few;
  logic [31:0]     bv_u;
  logic [31:0]     mode_ip;
  logic signed [32:0] msum;
  logic signed [32:0] med;
  logic signed [ValueW-1:0] val;
  logic            inv;

  assign few = count_q < CW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.emit_go) begin
      k_q <= StatCount;
    end else if (cmd_i.emit_step) begin
      k_q <= k_q + IdxW'(1);
    end
  end

  always_comb begin
    bv_u    = best_val_q;
    // fraction truncated toward zero
    mode_ip = best_val_q[31] ? ((bv_u + FracMask) & ~FracMask) : (bv_u & ~FracMask);
    msum    = {s_m1_q[31], s_m1_q} + {s_q2_q[31], s_q2_q};
    // both arms signed so the halving shift stays arithmetic
    med     = count_q[0] ? $signed({s_q2_q[31], s_q2_q}) : (msum >>> 1);
    val     = '0;
    inv     = dropped_q;
    unique case (k_q)
      StatCount:  val = ValueW'(count_q);
      StatSum:    val = ValueW'(sum_q);
      StatMean:   val = ValueW'(mean_q);
      StatMode: begin
        val = (best_len_q > CW'(1)) ? ValueW'($signed(mode_ip)) : '0;
        inv = dropped_q | (best_len_q < CW'(2));
      end
      StatQ1:     val = ValueW'(s_q1_q);
      StatQ2:     val = ValueW'(s_q2_q);
      StatQ3:     val = ValueW'(s_q3_q);
      StatRange:  val = ValueW'(s_hi_q) - ValueW'(s_lo_q);
      StatMedian: val = ValueW'(med);
      StatVar: begin
        val = few ? '0 : $signed(var_q);
        inv = dropped_q | few | var_sat_q;
      end
      StatStddev: begin
        val = few ? '0 : $signed(sres_q);
        inv = dropped_q | few;
      end
      StatIqr:    val = ValueW'(s_q3_q) - ValueW'(s_q1_q);
      default:    val = '0;
    endcase
  end

  always_comb begin
    out_data_o.stat_index   = k_q;
    out_data_o.stat_value   = val;
    out_data_o.stat_invalid = inv;
    out_data_o.last_result  = (k_q == StatIqr);
  end

  always_comb begin
    sts_o.full       = full;
    sts_o.cnt_zero   = (count_q == '0);
    sts_o.p_one      = (p_q == AW'(1));
    sts_o.larger     = rd_q > v_q;
    sts_o.last       = last_q;
    sts_o.div_done   = div_done;
    sts_o.sweep_done = (sa_q == count_q) && !v1_q && !v2_q && !v3_q;
    sts_o.mul_done   = (mcnt_q == MulCntW'(CW));
    sts_o.sqrt_done  = (sbit_q == '0);
    sts_o.few        = few;
    sts_o.emit_last  = (k_q == StatIqr);
  end

  a_shift_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> (p_q != '0))
    else $error("insertion shift below slot zero");

  a_drop_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dropped_q) |-> ($past(count_q) == CW'(MAX_SAMPLES)))
    else $error("sample dropped with room left");

  a_sweep_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (i1_q < count_q))
    else $error("sweep read beyond stored samples");

endmodule

`default_nettype wire

/* design/ses_ctrl.sv */
// controller state machine: insertion, statistics phases and result burst
// depends on ses_pkg
`default_nettype none

module ses_ctrl import ses_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  input  logic     out_stall_i,
  input  ses_sts_t sts_i,
  output ses_cmd_t cmd_o,
  output logic     in_stall_o,
  output logic     out_valid_o
);

  ses_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.full) begin
            // store full: request dropped, a final mark still ends the run
            if (in_last_i) begin
              cmd_o.mean_go = 1'b1;
              state_d       = ST_MEAN;
            end
          end else if (sts_i.cnt_zero) begin
            state_d = ST_PLACE;
          end else begin
            state_d = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if (sts_i.larger) begin
          cmd_o.shift = 1'b1;
          if (sts_i.p_one) state_d = ST_PLACE;
        end else begin
          cmd_o.place = 1'b1;
          if (sts_i.last) begin
            cmd_o.mean_go = 1'b1;
            state_d       = ST_MEAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PLACE: begin
        cmd_o.place = 1'b1;
        if (sts_i.last) begin
          cmd_o.mean_go = 1'b1;
          state_d       = ST_MEAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MEAN: begin
        if (sts_i.div_done) begin
          cmd_o.sweep_go = 1'b1;
          state_d        = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_done) begin
          if (sts_i.few) begin
            cmd_o.emit_go = 1'b1;
            state_d       = ST_EMIT;
          end else begin
            cmd_o.mul_go = 1'b1;
            state_d      = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (sts_i.mul_done) begin
          cmd_o.var_go = 1'b1;
          state_d      = ST_VAR;
        end
      end
      ST_VAR: begin
        if (sts_i.div_done) begin
          cmd_o.sqrt_go = 1'b1;
          state_d       = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sts_i.sqrt_done) begin
          cmd_o.emit_go = 1'b1;
          state_d       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.emit_step = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during result burst");

  a_burst_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && sts_i.emit_last) |=> !out_valid_o && !in_stall_o)
    else $error("burst did not end after final result");

endmodule

`default_nettype wire
